[rtl/prps_pkg.sv]
`timescale 1ns / 1ps

package prps_pkg;

  // Default sizes
  localparam int ANGLE_STEPS_DEF = 360;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEFF_BITS_DEF  = 16;

  // Fixed field widths
  localparam int REQ_W       = 2;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_W       = 10;
  localparam int STRIDE_W    = 7;
  localparam int QUERY_W     = 9;
  localparam int ANGLE_OUT_W = 9;
  // Unwrapped sweep angle: config range plus one stride
  localparam int ANG_W       = 12;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SWEEP_START  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SWEEP_END    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SWEEP_STRIDE = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0]    SWEEP_START_RST  = 10'd0;
  localparam logic [CFG_W-1:0]    SWEEP_END_RST    = 10'd360;
  localparam logic [STRIDE_W-1:0] SWEEP_STRIDE_RST = 7'd24;

  // pi in unsigned Q30
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam int TAYLOR_TERMS = 12;
  // (2k)(2k+1) and (2k-1)(2k) for k = 1..12
  localparam logic [63:0] TAYLOR_DIV_S [TAYLOR_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };
  localparam logic [63:0] TAYLOR_DIV_C [TAYLOR_TERMS] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP,
    ST_ROT_RD,
    ST_MUL_COS,
    ST_MUL_SIN,
    ST_SUM,
    ST_UPDATE,
    ST_Q_RD,
    ST_RESP
  } state_e;

  // Sine or cosine of x (unsigned Q30, 0..pi/2), truncated series, Q30 result.
  // Used for table elaboration only.
  function automatic logic [63:0] taylor_q30(input logic [63:0] x, input logic want_cos);
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] tc;
    logic [63:0] ss;
    logic [63:0] cc;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    ss = ts;
    cc = tc;
    for (int k = 0; k < TAYLOR_TERMS; k++) begin
      ts = ((ts * x2) >> 30) / TAYLOR_DIV_S[k];
      tc = ((tc * x2) >> 30) / TAYLOR_DIV_C[k];
      if ((k % 2) == 0) begin
        ss = ss - ts;
        cc = cc - tc;
      end else begin
        ss = ss + ts;
        cc = cc + tc;
      end
    end
    return want_cos ? cc : ss;
  endfunction

  // Round a Q30 value half up to frac fraction bits
  function automatic logic [63:0] q30_to_coeff(input logic [63:0] v, input int frac);
    int sh;
    sh = 30 - frac;
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

endpackage

[rtl/phase_rotated_peak_sweep_core.sv]
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                   | Word
// ----------+-----------+-----------------------------+------------------------------------------
// cfg       | in        | cfg_we_i (no wait)          | cfg_addr_i, cfg_data_i
// in        | in        | in_valid_i / in_ready_o     | req_type_i, sample_direct_i,
//           |           |                             | sample_quad_i, warmup_i, query_angle_i
// out       | out       | out_valid_o / out_ready_i   | peak_value_o, peak_angle_o
//
// One word at a time. An update, per swept angle, folds the angle in the shared add/subtract loop
// (ST_WRAP), then steps through ST_ROT_RD, ST_MUL_COS, ST_MUL_SIN, ST_SUM and ST_UPDATE; the single shared
// multiplier forms the cosine and the sine product in turn.
// A read folds its query angle in the same loop; a clear writes one table entry per cycle.
// After reset the peak table is swept to zero before in_ready_o rises.
// A pending result does not block the next word; a read waits only for the output register.

module phase_rotated_peak_sweep_core #(
  parameter int ANGLE_STEPS = prps_pkg::ANGLE_STEPS_DEF,
  parameter int SAMPLE_BITS = prps_pkg::SAMPLE_BITS_DEF,
  parameter int COEFF_BITS  = prps_pkg::COEFF_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [prps_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [prps_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [prps_pkg::REQ_W-1:0]           req_type_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_direct_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_quad_i,
  input  logic                                 warmup_i,
  input  logic [prps_pkg::QUERY_W-1:0]         query_angle_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [SAMPLE_BITS-1:0]               peak_value_o,
  output logic [prps_pkg::ANGLE_OUT_W-1:0]     peak_angle_o
);

  localparam int IDX_W  = $clog2(ANGLE_STEPS);
  localparam int CFRAC  = COEFF_BITS - 2;
  localparam int PROD_W = COEFF_BITS + SAMPLE_BITS;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RND_W  = SUM_W + 1;
  localparam int MAG_W  = RND_W - CFRAC;
  localparam int WRAP_W = ((IDX_W > prps_pkg::CFG_W) ? IDX_W : prps_pkg::CFG_W) + 2;
  localparam int ANG_W  = prps_pkg::ANG_W;

  localparam logic signed [WRAP_W-1:0] STEPS_W  = WRAP_W'(ANGLE_STEPS);
  localparam logic [IDX_W-1:0]         LAST_IDX = IDX_W'(ANGLE_STEPS - 1);
  localparam logic [RND_W-1:0]         HALF_POS = RND_W'(1) << (CFRAC - 1);
  localparam logic [RND_W-1:0]         HALF_NEG = HALF_POS + RND_W'(1);

  // Rotation coefficient ROM, built at elaboration
  logic signed [COEFF_BITS-1:0] cos_rom [ANGLE_STEPS];
  logic signed [COEFF_BITS-1:0] sin_rom [ANGLE_STEPS];

  for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_rot
    localparam bit          MIRROR = (2 * g > ANGLE_STEPS);
    localparam int          B      = MIRROR ? ANGLE_STEPS - g : g;
    localparam logic [63:0] X      = (64'(B) * prps_pkg::PI_Q30) / 64'(ANGLE_STEPS);
    localparam logic [63:0] CQ     =
      prps_pkg::q30_to_coeff(prps_pkg::taylor_q30(X, 1'b1), CFRAC);
    localparam logic [63:0] SQ     =
      prps_pkg::q30_to_coeff(prps_pkg::taylor_q30(X, 1'b0), CFRAC);
    localparam logic [COEFF_BITS-1:0] COS_V = MIRROR ? COEFF_BITS'(-CQ) : COEFF_BITS'(CQ);
    localparam logic [COEFF_BITS-1:0] SIN_V = COEFF_BITS'(-SQ);
    assign cos_rom[g] = COS_V;
    assign sin_rom[g] = SIN_V;
  end

  // Peak table
  logic [SAMPLE_BITS-1:0] peak_mem [ANGLE_STEPS];

  // Configuration registers
  logic signed [prps_pkg::CFG_W-1:0]    start_q;
  logic signed [prps_pkg::CFG_W-1:0]    end_q;
  logic        [prps_pkg::STRIDE_W-1:0] stride_q;

  // Control
  prps_pkg::state_e state_q, state_d;
  logic [IDX_W-1:0] clr_q;
  logic             out_valid_q;

  // Datapath
  logic                          is_query_q;
  logic signed [SAMPLE_BITS-1:0] d_q;
  logic signed [SAMPLE_BITS-1:0] q_q;
  logic signed [ANG_W-1:0]       ang_q;
  logic signed [WRAP_W-1:0]      wrap_q;
  logic signed [COEFF_BITS-1:0]  cos_q;
  logic signed [COEFF_BITS-1:0]  sin_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [PROD_W-1:0]      acc_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic [SAMPLE_BITS-1:0]        peak_rd_q;
  logic [SAMPLE_BITS-1:0]        out_value_q;
  logic [prps_pkg::ANGLE_OUT_W-1:0] out_angle_q;

  logic                          accept;
  logic [prps_pkg::STRIDE_W-1:0] stride_eff;
  logic signed [ANG_W-1:0]       start_ext;
  logic signed [ANG_W-1:0]       end_ext;
  logic signed [ANG_W-1:0]       ang_next;
  logic                          sweep_done;
  logic                          wrap_neg;
  logic                          wrap_hi;
  logic [IDX_W-1:0]              idx;
  logic signed [COEFF_BITS-1:0]  mul_a;
  logic signed [SAMPLE_BITS-1:0] mul_b;
  logic signed [PROD_W-1:0]      mul_p;
  logic [RND_W-1:0]              rnd;
  logic [MAG_W-1:0]              mag;
  logic [SAMPLE_BITS-1:0]        new_peak;
  logic                          raise;
  logic                          out_free;
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_waddr;
  logic [SAMPLE_BITS-1:0]        mem_wdata;

  assign in_ready_o   = (state_q == prps_pkg::ST_IDLE);
  assign accept       = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign peak_value_o = out_value_q;
  assign peak_angle_o = out_angle_q;
  assign out_free     = !out_valid_q || out_ready_i;

  // Zero stride acts as one
  assign stride_eff = (stride_q == '0) ? prps_pkg::STRIDE_W'(1) : stride_q;
  assign start_ext  = ANG_W'(start_q);
  assign end_ext    = ANG_W'(end_q);
  assign ang_next   = ang_q + $signed(ANG_W'(stride_eff));
  assign sweep_done = (ang_next >= end_ext);

  assign wrap_neg = wrap_q[WRAP_W-1];
  assign wrap_hi  = !wrap_neg && (wrap_q >= STEPS_W);
  assign idx      = wrap_q[IDX_W-1:0];

  // Shared multiplier: cosine term, then sine term
  assign mul_a = (state_q == prps_pkg::ST_MUL_SIN) ? sin_q : cos_q;
  assign mul_b = (state_q == prps_pkg::ST_MUL_SIN) ? q_q : d_q;
  assign mul_p = mul_a * mul_b;

  // |sum| rounded half up: for a negative sum, ~sum + 1 is the magnitude
  always_comb begin
    if (sum_q[SUM_W-1]) begin
      rnd = RND_W'($unsigned(~sum_q)) + HALF_NEG;
    end else begin
      rnd = RND_W'($unsigned(sum_q)) + HALF_POS;
    end
  end
  assign mag      = rnd[RND_W-1:CFRAC];
  assign new_peak = (|mag[MAG_W-1:SAMPLE_BITS]) ? '1 : mag[SAMPLE_BITS-1:0];
  assign raise    = (new_peak > peak_rd_q);

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = new_peak;
    case (state_q)
      prps_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == LAST_IDX) begin
          state_d = prps_pkg::ST_IDLE;
        end
      end
      prps_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            prps_pkg::REQ_UPDATE: begin
              if (!warmup_i && (start_ext <= end_ext)) begin
                state_d = prps_pkg::ST_WRAP;
              end
            end
            prps_pkg::REQ_READ:  state_d = prps_pkg::ST_WRAP;
            prps_pkg::REQ_CLEAR: state_d = prps_pkg::ST_CLEAR;
            default:             state_d = prps_pkg::ST_IDLE;
          endcase
        end
      end
      prps_pkg::ST_WRAP: begin
        if (!wrap_neg && !wrap_hi) begin
          state_d = is_query_q ? prps_pkg::ST_Q_RD : prps_pkg::ST_ROT_RD;
        end
      end
      prps_pkg::ST_ROT_RD:  state_d = prps_pkg::ST_MUL_COS;
      prps_pkg::ST_MUL_COS: state_d = prps_pkg::ST_MUL_SIN;
      prps_pkg::ST_MUL_SIN: state_d = prps_pkg::ST_SUM;
      prps_pkg::ST_SUM:     state_d = prps_pkg::ST_UPDATE;
      prps_pkg::ST_UPDATE: begin
        mem_we  = raise;
        state_d = sweep_done ? prps_pkg::ST_IDLE : prps_pkg::ST_WRAP;
      end
      prps_pkg::ST_Q_RD: state_d = prps_pkg::ST_RESP;
      prps_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = prps_pkg::ST_IDLE;
        end
      end
      default: state_d = prps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= prps_pkg::SWEEP_START_RST;
      end_q    <= prps_pkg::SWEEP_END_RST;
      stride_q <= prps_pkg::SWEEP_STRIDE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        prps_pkg::CFG_SWEEP_START:  start_q  <= cfg_data_i;
        prps_pkg::CFG_SWEEP_END:    end_q    <= cfg_data_i;
        prps_pkg::CFG_SWEEP_STRIDE: stride_q <= cfg_data_i[prps_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prps_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == prps_pkg::ST_CLEAR) begin
        clr_q <= (clr_q == LAST_IDX) ? '0 : clr_q + IDX_W'(1);
      end
      if (state_q == prps_pkg::ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      prps_pkg::ST_IDLE: begin
        if (accept) begin
          d_q        <= sample_direct_i;
          q_q        <= sample_quad_i;
          ang_q      <= start_ext;
          is_query_q <= (req_type_i == prps_pkg::REQ_READ);
          if (req_type_i == prps_pkg::REQ_READ) begin
            wrap_q <= $signed(WRAP_W'(query_angle_i));
          end else begin
            wrap_q <= WRAP_W'(start_ext);
          end
        end
      end
      prps_pkg::ST_WRAP: begin
        // Fold into [0, ANGLE_STEPS) one step per cycle
        if (wrap_neg) begin
          wrap_q <= wrap_q + STEPS_W;
        end else if (wrap_hi) begin
          wrap_q <= wrap_q - STEPS_W;
        end
      end
      prps_pkg::ST_MUL_COS: prod_q <= mul_p;
      prps_pkg::ST_MUL_SIN: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      prps_pkg::ST_SUM: sum_q <= SUM_W'(acc_q) + SUM_W'(prod_q);
      prps_pkg::ST_UPDATE: begin
        ang_q  <= ang_next;
        wrap_q <= wrap_q + $signed(WRAP_W'(stride_eff));
      end
      prps_pkg::ST_RESP: begin
        if (out_free) begin
          out_value_q <= peak_rd_q;
          out_angle_q <= wrap_q[prps_pkg::ANGLE_OUT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Registered reads of the coefficient ROM and the peak table
  always_ff @(posedge clk_i) begin
    if (state_q == prps_pkg::ST_ROT_RD) begin
      cos_q <= cos_rom[idx];
      sin_q <= sin_rom[idx];
    end
    if (state_q == prps_pkg::ST_ROT_RD || state_q == prps_pkg::ST_Q_RD) begin
      peak_rd_q <= peak_mem[idx];
    end
    if (mem_we) begin
      peak_mem[mem_waddr] <= mem_wdata;
    end
  end

endmodule

[rtl/prps_checker.sv]
`timescale 1ns / 1ps

module prps_checker #(
  parameter int ANGLE_STEPS = prps_pkg::ANGLE_STEPS_DEF,
  parameter int SAMPLE_BITS = prps_pkg::SAMPLE_BITS_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic [prps_pkg::REQ_W-1:0]       req_type_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [SAMPLE_BITS-1:0]           peak_value_o,
  input logic [prps_pkg::ANGLE_OUT_W-1:0] peak_angle_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(peak_value_o) && $stable(peak_angle_o))
    else $error("stalled result word changed or dropped");

  // Only a read produces a result
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && req_type_i != prps_pkg::REQ_READ |=> !$rose(out_valid_o))
    else $error("result word appeared after a non-read word");

  // A read occupies the block
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && req_type_i == prps_pkg::REQ_READ |=> !in_ready_o)
    else $error("ready high right after accepting a read");

  // A clear sweeps the table before the next word
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && req_type_i == prps_pkg::REQ_CLEAR |=> !in_ready_o)
    else $error("ready high right after accepting a clear");

  // Reported angle is always wrapped
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(peak_angle_o) < ANGLE_STEPS)
    else $error("reported angle out of range");

endmodule

bind phase_rotated_peak_sweep_core prps_checker #(
  .ANGLE_STEPS(ANGLE_STEPS),
  .SAMPLE_BITS(SAMPLE_BITS)
) u_prps_checker (.*);
